>>> rtl/dprhf_pkg.sv
// Shared types and constants for the depth pixel range and height filter.
package dprhf_pkg;

	// Field and register widths
	localparam int DEPTH_W   = 16;
	localparam int FOCAL_W   = 20;
	localparam int CENTER_W  = 16;
	localparam int LIMIT_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 20;

	// Position as seen by the projection (column or row, up to 4096 lines)
	localparam int POS_W     = 12;
	// Signed offset pos*16 - center, and its magnitude
	localparam int OFF_W     = 17;
	localparam int MAG_W     = 16;
	// Numerator magnitude |off|*z and the quotient that replaces it
	localparam int NUM_W     = 32;
	localparam int DIV_CNT_W = 5;
	// Saturated lateral and vertical offsets
	localparam int XY_W      = 18;
	localparam logic [NUM_W-1:0] XY_POS_LIMIT = NUM_W'(131071);
	localparam logic [NUM_W-1:0] XY_NEG_LIMIT = NUM_W'(131072);
	// Squared distance
	localparam int SQ_W      = 36;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_X  = 3'd0,
		REG_CENTER_X = 3'd1,
		REG_FOCAL_Y  = 3'd2,
		REG_CENTER_Y = 3'd3,
		REG_MIN_DIST = 3'd4,
		REG_MAX_DIST = 3'd5,
		REG_MIN_HGT  = 3'd6,
		REG_MAX_HGT  = 3'd7
	} cfg_reg_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_DIV_X,
		ST_MUL_Y,
		ST_DIV_Y,
		ST_SQUARE,
		ST_COMPARE,
		ST_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;      // take the request from the input channel
		logic prod_x;    // lateral numerator into divider
		logic prod_y;    // vertical numerator into divider, store X
		logic div_step;  // one quotient bit
		logic square;    // store Y, square X
		logic compare;   // window tests
		logic emit;      // move result into the output register
		logic in_ready;  // input channel may take a request
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic in_valid;     // input request pending
		logic in_depth_ok;  // pending request carries a finite depth
		logic div_last;     // final quotient bit this cycle
		logic out_free;     // output register can be loaded
	} dp_status_t;

endpackage

>>> rtl/dprhf_if.sv
// Stream interfaces for the pixel input and the filtered output.
interface dprhf_in_if;
	logic                           valid;
	logic                           ready;
	logic [dprhf_pkg::DEPTH_W-1:0]  depth_mm;
	logic                           depth_valid;
	logic                           row_end;
	logic                           frame_start;

	modport source (output valid, depth_mm, depth_valid, row_end, frame_start, input ready);
	modport sink   (input valid, depth_mm, depth_valid, row_end, frame_start, output ready);
endinterface

interface dprhf_out_if;
	logic                           valid;
	logic                           ready;
	logic [dprhf_pkg::DEPTH_W-1:0]  depth_out;
	logic                           valid_out;
	logic                           rejected;

	modport source (output valid, depth_out, valid_out, rejected, input ready);
	modport sink   (input valid, depth_out, valid_out, rejected, output ready);
endinterface

>>> rtl/depth_pixel_range_height_filter_top.sv
// A valid pixel passes both divisions, the squares and the window tests before its result enters the
// output register; an invalid pixel's result goes there directly. One pixel is processed at a time; the shared
// one-bit-per-cycle divider runs 32 steps for X and 32 for Y.
// A finished result waits in the output register while the next pixel is taken.
// Reset (arst_n low, asynchronous): counters at column 0 row 0, output empty,
// configuration registers at their defaults.
module depth_pixel_range_height_filter_top #(
	parameter int MAX_COLS = 4096,
	parameter int MAX_ROWS = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dprhf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dprhf_pkg::CFG_DAT_W-1:0] cfg_data,
	dprhf_in_if.sink                        pixel,
	dprhf_out_if.source                     result
);

	dprhf_pkg::dp_cmd_t    cmd;
	dprhf_pkg::dp_status_t status;

	// Sequencer
	dprhf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// Arithmetic and storage
	dprhf_datapath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.pixel     (pixel),
		.result    (result)
	);

endmodule

>>> rtl/dprhf_ctrl.sv
// Filter FSM: accept, two divisions, squares, tests, output (invalid depth: output only).
module dprhf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dprhf_pkg::dp_status_t status,
	output dprhf_pkg::dp_cmd_t    cmd
);

	dprhf_pkg::state_t state_q;
	dprhf_pkg::state_t state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dprhf_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			dprhf_pkg::ST_IDLE: begin
				if (status.in_valid) begin
					state_next = status.in_depth_ok ? dprhf_pkg::ST_MUL_X : dprhf_pkg::ST_DONE;
				end
			end
			dprhf_pkg::ST_MUL_X: begin
				state_next = dprhf_pkg::ST_DIV_X;
			end
			dprhf_pkg::ST_DIV_X: begin
				if (status.div_last) begin
					state_next = dprhf_pkg::ST_MUL_Y;
				end
			end
			dprhf_pkg::ST_MUL_Y: begin
				state_next = dprhf_pkg::ST_DIV_Y;
			end
			dprhf_pkg::ST_DIV_Y: begin
				if (status.div_last) begin
					state_next = dprhf_pkg::ST_SQUARE;
				end
			end
			dprhf_pkg::ST_SQUARE: begin
				state_next = dprhf_pkg::ST_COMPARE;
			end
			dprhf_pkg::ST_COMPARE: begin
				state_next = dprhf_pkg::ST_DONE;
			end
			dprhf_pkg::ST_DONE: begin
				if (status.out_free) begin
					state_next = dprhf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = dprhf_pkg::ST_IDLE;
			end
		endcase
	end

	// Command outputs
	always_comb begin
		cmd = '0;
		unique case (state_q) inside
			dprhf_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.load     = status.in_valid;
			end
			dprhf_pkg::ST_MUL_X: begin
				cmd.prod_x = 1'b1;
			end
			dprhf_pkg::ST_DIV_X,
			dprhf_pkg::ST_DIV_Y: begin
				cmd.div_step = 1'b1;
			end
			dprhf_pkg::ST_MUL_Y: begin
				cmd.prod_y = 1'b1;
			end
			dprhf_pkg::ST_SQUARE: begin
				cmd.square = 1'b1;
			end
			dprhf_pkg::ST_COMPARE: begin
				cmd.compare = 1'b1;
			end
			dprhf_pkg::ST_DONE: begin
				cmd.emit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/dprhf_datapath.sv
// Datapath: config registers, raster counters, shared divider, squares, window tests, output register.
module dprhf_datapath #(
	parameter int MAX_COLS = 4096,
	parameter int MAX_ROWS = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dprhf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dprhf_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  dprhf_pkg::dp_cmd_t                cmd,
	output dprhf_pkg::dp_status_t             status,
	dprhf_in_if.sink                          pixel,
	dprhf_out_if.source                       result
);

	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

	// Configuration registers
	logic [dprhf_pkg::FOCAL_W-1:0]  focal_x_q, focal_y_q;
	logic [dprhf_pkg::CENTER_W-1:0] center_x_q, center_y_q;
	logic [dprhf_pkg::LIMIT_W-1:0]  min_dist_q, max_dist_q, min_hgt_q, max_hgt_q;

	// Raster counters and latched request
	logic [COL_W-1:0]               col_q;
	logic [ROW_W-1:0]               row_q;
	logic [COL_W-1:0]               col_cur;
	logic [ROW_W-1:0]               row_cur;
	logic [COL_W-1:0]               pix_col_q;
	logic [ROW_W-1:0]               pix_row_q;
	logic [dprhf_pkg::DEPTH_W-1:0]  depth_q;
	logic                           depth_ok_q;

	// Divider
	logic [dprhf_pkg::NUM_W-1:0]     num_q;
	logic [dprhf_pkg::FOCAL_W-1:0]   rem_q;
	logic [dprhf_pkg::FOCAL_W-1:0]   div_q;
	logic [dprhf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                            neg_q;
	logic [dprhf_pkg::FOCAL_W:0]     rem_shift;
	logic [dprhf_pkg::FOCAL_W:0]     rem_diff;
	logic                            q_bit;

	// Projection operands
	logic signed [dprhf_pkg::OFF_W-1:0] off_x, off_y, off_sel;
	logic [dprhf_pkg::MAG_W-1:0]        mag_sel;
	logic [dprhf_pkg::FOCAL_W-1:0]      focal_sel;
	logic [dprhf_pkg::XY_W-1:0]         quot_sat;

	// Results of the arithmetic steps
	logic signed [dprhf_pkg::XY_W-1:0]  x_q, y_q;
	logic [dprhf_pkg::SQ_W-1:0]         x2_q;
	logic [2*dprhf_pkg::DEPTH_W-1:0]    z2_q;
	logic [2*dprhf_pkg::LIMIT_W-1:0]    lo_q, hi_q;
	logic                               rej_q;
	logic [dprhf_pkg::SQ_W-1:0]         d2;
	logic signed [dprhf_pkg::XY_W:0]    y_ext, neg_min_hgt, neg_max_hgt;
	logic signed [2*dprhf_pkg::XY_W-1:0] x_sq;

	// Output register
	logic                           out_valid_q;
	logic [dprhf_pkg::DEPTH_W-1:0]  out_depth_q;
	logic                           out_ok_q;
	logic                           out_rej_q;

	// Handshake and status
	assign pixel.ready        = cmd.in_ready;
	assign status.in_valid    = pixel.valid;
	assign status.in_depth_ok = pixel.depth_valid;
	assign status.div_last    = (cnt_q == '1);
	assign status.out_free    = !out_valid_q || result.ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= dprhf_pkg::FOCAL_W'(8192);
			center_x_q <= dprhf_pkg::CENTER_W'(5120);
			focal_y_q  <= dprhf_pkg::FOCAL_W'(8192);
			center_y_q <= dprhf_pkg::CENTER_W'(3840);
			min_dist_q <= dprhf_pkg::LIMIT_W'(500);
			max_dist_q <= dprhf_pkg::LIMIT_W'(5000);
			min_hgt_q  <= dprhf_pkg::LIMIT_W'(100);
			max_hgt_q  <= dprhf_pkg::LIMIT_W'(2000);
		end else if (cfg_we) begin
			unique case (dprhf_pkg::cfg_reg_t'(cfg_index))
				dprhf_pkg::REG_FOCAL_X:  focal_x_q  <= cfg_data;
				dprhf_pkg::REG_CENTER_X: center_x_q <= cfg_data[dprhf_pkg::CENTER_W-1:0];
				dprhf_pkg::REG_FOCAL_Y:  focal_y_q  <= cfg_data;
				dprhf_pkg::REG_CENTER_Y: center_y_q <= cfg_data[dprhf_pkg::CENTER_W-1:0];
				dprhf_pkg::REG_MIN_DIST: min_dist_q <= cfg_data[dprhf_pkg::LIMIT_W-1:0];
				dprhf_pkg::REG_MAX_DIST: max_dist_q <= cfg_data[dprhf_pkg::LIMIT_W-1:0];
				dprhf_pkg::REG_MIN_HGT:  min_hgt_q  <= cfg_data[dprhf_pkg::LIMIT_W-1:0];
				dprhf_pkg::REG_MAX_HGT:  max_hgt_q  <= cfg_data[dprhf_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Position of the incoming pixel; frame start puts it at the origin
	assign col_cur = pixel.frame_start ? '0 : col_q;
	assign row_cur = pixel.frame_start ? '0 : row_q;

	// Raster counters advance on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load) begin
			if (pixel.row_end || col_cur == COL_LAST) begin
				col_q <= '0;
				row_q <= (row_cur == ROW_LAST) ? '0 : row_cur + 1'b1;
			end else begin
				col_q <= col_cur + 1'b1;
				row_q <= row_cur;
			end
		end
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_col_q  <= col_cur;
			pix_row_q  <= row_cur;
			depth_q    <= pixel.depth_mm;
			depth_ok_q <= pixel.depth_valid;
		end
	end

	// Signed offsets pos*16 - center
	assign off_x = $signed({1'b0, dprhf_pkg::POS_W'(pix_col_q), 4'b0000})
		- $signed({1'b0, center_x_q});
	assign off_y = $signed({1'b0, dprhf_pkg::POS_W'(pix_row_q), 4'b0000})
		- $signed({1'b0, center_y_q});
	assign off_sel   = cmd.prod_y ? off_y : off_x;
	assign mag_sel   = off_sel[dprhf_pkg::OFF_W-1] ? dprhf_pkg::MAG_W'(-off_sel)
		: off_sel[dprhf_pkg::MAG_W-1:0];
	assign focal_sel = cmd.prod_y ? focal_y_q : focal_x_q;

	// Restoring division step
	assign rem_shift = {rem_q, num_q[dprhf_pkg::NUM_W-1]};
	assign rem_diff  = rem_shift - {1'b0, div_q};
	assign q_bit     = !rem_diff[dprhf_pkg::FOCAL_W];

	// Saturate the signed quotient to 18 bits
	always_comb begin
		if (neg_q) begin
			quot_sat = (num_q > dprhf_pkg::XY_NEG_LIMIT) ? dprhf_pkg::XY_W'(-131072)
				: dprhf_pkg::XY_W'(-num_q);
		end else begin
			quot_sat = (num_q > dprhf_pkg::XY_POS_LIMIT) ? dprhf_pkg::XY_W'(131071)
				: num_q[dprhf_pkg::XY_W-1:0];
		end
	end

	// Numerator load and shared divider
	always_ff @(posedge clk) begin
		if (cmd.prod_x || cmd.prod_y) begin
			num_q <= dprhf_pkg::NUM_W'(mag_sel) * dprhf_pkg::NUM_W'(depth_q);
			neg_q <= off_sel[dprhf_pkg::OFF_W-1];
			div_q <= (focal_sel == '0) ? dprhf_pkg::FOCAL_W'(1) : focal_sel;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[dprhf_pkg::NUM_W-2:0], q_bit};
			rem_q <= q_bit ? rem_diff[dprhf_pkg::FOCAL_W-1:0]
				: rem_shift[dprhf_pkg::FOCAL_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Squares of the depth, the distance limits and X, and the stored X and Y quotients
	always_ff @(posedge clk) begin
		if (cmd.prod_x) begin
			z2_q <= dprhf_pkg::NUM_W'(depth_q) * dprhf_pkg::NUM_W'(depth_q);
		end
		if (cmd.prod_y) begin
			x_q  <= quot_sat;
			lo_q <= dprhf_pkg::NUM_W'(min_dist_q) * dprhf_pkg::NUM_W'(min_dist_q);
			hi_q <= dprhf_pkg::NUM_W'(max_dist_q) * dprhf_pkg::NUM_W'(max_dist_q);
		end
		if (cmd.square) begin
			y_q  <= quot_sat;
			x2_q <= x_sq[dprhf_pkg::SQ_W-1:0];
		end
	end

	assign x_sq = dprhf_pkg::SQ_W'(x_q) * dprhf_pkg::SQ_W'(x_q);

	// Window tests
	assign d2          = x2_q + dprhf_pkg::SQ_W'(z2_q);
	assign y_ext       = $signed({y_q[dprhf_pkg::XY_W-1], y_q});
	assign neg_min_hgt = -$signed({3'b000, min_hgt_q});
	assign neg_max_hgt = -$signed({3'b000, max_hgt_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rej_q <= 1'b0;
		end else if (cmd.compare) begin
			rej_q <= (d2 < dprhf_pkg::SQ_W'(lo_q)) || (d2 > dprhf_pkg::SQ_W'(hi_q))
				|| (y_ext > neg_min_hgt) || (y_ext < neg_max_hgt);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_depth_q <= depth_q;
			out_ok_q    <= depth_ok_q && !rej_q;
			out_rej_q   <= rej_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.depth_out = out_depth_q;
	assign result.valid_out = out_ok_q;
	assign result.rejected  = out_rej_q;

endmodule

>>> tb/depth_pixel_range_height_filter_top_tb.sv
// Self-checking testbench for the depth pixel range and height filter top level.
module depth_pixel_range_height_filter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS        = 32;
	localparam int ROWS        = 32;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN       = 100;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 60;

	typedef struct {
		logic [dprhf_pkg::DEPTH_W-1:0] depth_mm;
		logic                          depth_valid;
		logic                          row_end;
		logic                          frame_start;
	} pixel_t;

	typedef struct {
		logic [dprhf_pkg::DEPTH_W-1:0] depth_out;
		logic                          valid_out;
		logic                          rejected;
	} filtered_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [dprhf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dprhf_pkg::CFG_DAT_W-1:0] cfg_data;

	dprhf_in_if  pix_if ();
	dprhf_out_if res_if ();

	depth_pixel_range_height_filter_top #(
		.MAX_COLS(COLS),
		.MAX_ROWS(ROWS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixel    (pix_if),
		.result   (res_if)
	);

	// Pixels waiting to be offered and results predicted for accepted pixels
	pixel_t    pixel_queue[$];
	filtered_t expected_results[$];
	pixel_t    offered;
	filtered_t want;

	int fail_count;
	int src_idle_pct;
	int snk_stall_pct;
	logic pressure_go;
	logic hold_off;

	// Predictor copy of the registers and the raster position
	logic [dprhf_pkg::FOCAL_W-1:0]  m_focal_x, m_focal_y;
	logic [dprhf_pkg::CENTER_W-1:0] m_center_x, m_center_y;
	logic [dprhf_pkg::LIMIT_W-1:0]  m_min_dist, m_max_dist, m_min_hgt, m_max_hgt;
	logic [dprhf_pkg::POS_W-1:0]    col_cnt, row_cnt;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Pinhole offset along one axis, truncated toward zero, saturated to 18 bits signed
	function automatic longint project_axis(input logic [dprhf_pkg::POS_W-1:0] pos,
		input logic [dprhf_pkg::CENTER_W-1:0] center,
		input logic [dprhf_pkg::FOCAL_W-1:0] focal,
		input logic [dprhf_pkg::DEPTH_W-1:0] z);
		longint pos_l, ctr_l, z_l, divisor, q;
		pos_l   = pos;
		ctr_l   = center;
		z_l     = z;
		divisor = focal;
		if (divisor == 0)
			divisor = 1;
		q = ((pos_l * 16 - ctr_l) * z_l) / divisor;
		if (q > 131071)
			q = 131071;
		if (q < -131072)
			q = -131072;
		return q;
	endfunction

	// Expected filter output for one accepted pixel; advances the raster position
	function automatic filtered_t filter_pixel(input pixel_t p);
		filtered_t r;
		longint x, y, z_l, d2, lo, hi, hmin, hmax;
		logic rej;
		rej = 1'b0;
		if (p.frame_start) begin
			col_cnt = '0;
			row_cnt = '0;
		end
		if (p.depth_valid) begin
			x    = project_axis(col_cnt, m_center_x, m_focal_x, p.depth_mm);
			y    = project_axis(row_cnt, m_center_y, m_focal_y, p.depth_mm);
			z_l  = p.depth_mm;
			lo   = m_min_dist;
			hi   = m_max_dist;
			hmin = m_min_hgt;
			hmax = m_max_hgt;
			d2   = x * x + z_l * z_l;
			if (d2 < lo * lo || d2 > hi * hi || y > -hmin || y < -hmax)
				rej = 1'b1;
		end
		r.depth_out = p.depth_mm;
		r.valid_out = p.depth_valid && !rej;
		r.rejected  = rej;
		if (p.row_end || col_cnt >= COLS - 1) begin
			col_cnt = '0;
			if (row_cnt >= ROWS - 1)
				row_cnt = '0;
			else
				row_cnt = row_cnt + 1'b1;
		end else begin
			col_cnt = col_cnt + 1'b1;
		end
		return r;
	endfunction

	// Driver: offer queued pixels, hold each until the block takes it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
		end else begin
			if (pix_if.valid && pix_if.ready)
				expected_results.push_back(filter_pixel(offered));
			if (!pix_if.valid || pix_if.ready) begin
				if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					offered = pixel_queue.pop_front();
					pix_if.valid       <= 1'b1;
					pix_if.depth_mm    <= offered.depth_mm;
					pix_if.depth_valid <= offered.depth_valid;
					pix_if.row_end     <= offered.row_end;
					pix_if.frame_start <= offered.frame_start;
				end else begin
					pix_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: depth %0d valid %0b rejected %0b",
							res_if.depth_out, res_if.valid_out, res_if.rejected);
				end else begin
					want = expected_results.pop_front();
					if (res_if.depth_out !== want.depth_out ||
						res_if.valid_out !== want.valid_out ||
						res_if.rejected !== want.rejected) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: depth %0d/%0d valid %0b/%0b rejected %0b/%0b (exp/act)",
								want.depth_out, res_if.depth_out, want.valid_out,
								res_if.valid_out, want.rejected, res_if.rejected);
					end
				end
			end
			if (hold_off)
				res_if.ready <= 1'b0;
			else
				res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// Long receiver hold-off, counted here, so the block backs up into its input
	initial begin
		hold_off = 1'b0;
		wait (pressure_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Run guard
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [dprhf_pkg::DEPTH_W-1:0] rand_depth();
		case ($urandom_range(0, 7))
			0: return dprhf_pkg::DEPTH_W'($urandom_range(0, 65535));
			1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return dprhf_pkg::DEPTH_W'($urandom_range(200, 7000));
		endcase
	endfunction

	task automatic add_pixel(input logic [dprhf_pkg::DEPTH_W-1:0] z, input logic v,
		input logic re, input logic fs);
		pixel_t p;
		p.depth_mm    = z;
		p.depth_valid = v;
		p.row_end     = re;
		p.frame_start = fs;
		pixel_queue.push_back(p);
	endtask

	// Well-formed frame: start mark on the first pixel, end mark on each row's last
	task automatic add_frame(input int rows, input int max_width, ref int count);
		int w;
		for (int r = 0; r < rows; r++) begin
			w = $urandom_range(1, max_width);
			for (int c = 0; c < w; c++) begin
				add_pixel(rand_depth(), $urandom_range(0, 99) < 80, c == w - 1,
					r == 0 && c == 0);
				count++;
			end
		end
	endtask

	// Write every register, keeping the predictor copy in step
	task automatic write_config(input logic [dprhf_pkg::CFG_DAT_W-1:0] fx,
		input logic [dprhf_pkg::CFG_DAT_W-1:0] cx,
		input logic [dprhf_pkg::CFG_DAT_W-1:0] fy,
		input logic [dprhf_pkg::CFG_DAT_W-1:0] cy,
		input logic [dprhf_pkg::CFG_DAT_W-1:0] dmin,
		input logic [dprhf_pkg::CFG_DAT_W-1:0] dmax,
		input logic [dprhf_pkg::CFG_DAT_W-1:0] hmin,
		input logic [dprhf_pkg::CFG_DAT_W-1:0] hmax);
		logic [dprhf_pkg::CFG_DAT_W-1:0] vals[8];
		dprhf_pkg::cfg_reg_t idx;
		vals = '{fx, cx, fy, cy, dmin, dmax, hmin, hmax};
		idx = dprhf_pkg::REG_FOCAL_X;
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[i];
			case (idx)
				dprhf_pkg::REG_FOCAL_X:  m_focal_x  = vals[i];
				dprhf_pkg::REG_CENTER_X: m_center_x = vals[i][dprhf_pkg::CENTER_W-1:0];
				dprhf_pkg::REG_FOCAL_Y:  m_focal_y  = vals[i];
				dprhf_pkg::REG_CENTER_Y: m_center_y = vals[i][dprhf_pkg::CENTER_W-1:0];
				dprhf_pkg::REG_MIN_DIST: m_min_dist = vals[i][dprhf_pkg::LIMIT_W-1:0];
				dprhf_pkg::REG_MAX_DIST: m_max_dist = vals[i][dprhf_pkg::LIMIT_W-1:0];
				dprhf_pkg::REG_MIN_HGT:  m_min_hgt  = vals[i][dprhf_pkg::LIMIT_W-1:0];
				dprhf_pkg::REG_MAX_HGT:  m_max_hgt  = vals[i][dprhf_pkg::LIMIT_W-1:0];
				default: ;
			endcase
			idx = idx.next();
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Let the queued pixels through with the given idling, then wait until all results are in
	task automatic run_phase(input int profile);
		int src_pct[4];
		int snk_pct[4];
		src_pct = '{0, 63, 0, 18};
		snk_pct = '{0, 0, 63, 18};
		src_idle_pct  = src_pct[profile % 4];
		snk_stall_pct = snk_pct[profile % 4];
		do @(negedge clk);
		while (pixel_queue.size() != 0 || pix_if.valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Main sequence
	initial begin
		int count;
		int frame_n;
		fail_count         = 0;
		src_idle_pct       = 0;
		snk_stall_pct      = 0;
		pressure_go        = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		pix_if.valid       = 1'b0;
		pix_if.depth_mm    = '0;
		pix_if.depth_valid = 1'b0;
		pix_if.row_end     = 1'b0;
		pix_if.frame_start = 1'b0;
		res_if.ready       = 1'b0;
		m_focal_x  = 20'd8192;
		m_center_x = 16'd5120;
		m_focal_y  = 20'd8192;
		m_center_y = 16'd3840;
		m_min_dist = 16'd500;
		m_max_dist = 16'd5000;
		m_min_hgt  = 16'd100;
		m_max_hgt  = 16'd2000;
		col_cnt    = '0;
		row_cnt    = '0;
		arst_n     = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: extremes of depth, invalid pixels, row end, frame start mid-row
		add_pixel(16'd1000, 1'b1, 1'b0, 1'b1);
		add_pixel(16'd0,    1'b1, 1'b0, 1'b0);
		add_pixel(16'hFFFF, 1'b1, 1'b0, 1'b0);
		add_pixel(16'hFFFF, 1'b0, 1'b0, 1'b0);
		add_pixel(16'd0,    1'b0, 1'b0, 1'b0);
		add_pixel(16'd500,  1'b1, 1'b0, 1'b0);
		add_pixel(16'd2000, 1'b1, 1'b1, 1'b0);
		add_pixel(16'd3000, 1'b1, 1'b0, 1'b0);
		add_pixel(16'd4000, 1'b1, 1'b1, 1'b1);
		add_pixel(16'd1500, 1'b1, 1'b1, 1'b0);
		add_pixel(16'd1200, 1'b1, 1'b0, 1'b1);
		run_phase(0);

		// Saturation of X and Y, widest windows
		write_config(20'd1, 20'd0, 20'd1, 20'hFFFF, 20'd0, 20'hFFFF, 20'd0, 20'hFFFF);
		add_pixel(16'hFFFF, 1'b1, 1'b0, 1'b1);
		add_pixel(16'hFFFF, 1'b1, 1'b1, 1'b0);
		add_pixel(16'd1,    1'b1, 1'b0, 1'b0);
		add_pixel(16'd0,    1'b1, 1'b1, 1'b0);
		run_phase(1);

		// Zero focal lengths act as one
		write_config(20'd0, 20'hFFFF, 20'd0, 20'd0, 20'd0, 20'hFFFF, 20'd0, 20'hFFFF);
		add_pixel(16'd7,    1'b1, 1'b0, 1'b1);
		add_pixel(16'd300,  1'b1, 1'b1, 1'b0);
		add_pixel(16'hFFFF, 1'b1, 1'b0, 1'b0);
		run_phase(2);

		// Crossed distance window, largest focal lengths
		write_config(20'hFFFFF, 20'd5120, 20'hFFFFF, 20'd3840, 20'd6000, 20'd100,
			20'd100, 20'd2000);
		add_pixel(16'd1000, 1'b1, 1'b0, 1'b1);
		add_pixel(16'd3000, 1'b1, 1'b1, 1'b0);
		add_pixel(16'd3000, 1'b0, 1'b0, 1'b0);
		run_phase(3);

		// Crossed height window
		write_config(20'd8192, 20'd5120, 20'd8192, 20'd3840, 20'd500, 20'd5000,
			20'd2000, 20'd100);
		add_pixel(16'd1000, 1'b1, 1'b0, 1'b1);
		add_pixel(16'd2500, 1'b1, 1'b1, 1'b0);
		run_phase(0);

		// Random frames under random settings, every idling profile
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			write_config(20'($urandom_range(2000, 20000)), 20'($urandom_range(0, 400)),
				20'($urandom_range(2000, 20000)), 20'($urandom_range(0, 400)),
				20'($urandom_range(0, 1500)), 20'($urandom_range(1000, 8000)),
				20'($urandom_range(0, 300)), 20'($urandom_range(200, 3000)));
			count = 0;
			while (count < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0) begin
					frame_n = $urandom_range(1, 6);
					for (int i = 0; i < frame_n; i++) begin
						add_pixel(rand_depth(), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
						count++;
					end
				end else begin
					add_frame($urandom_range(1, 6), 8, count);
				end
			end
			if (ph == 4)
				pressure_go = 1'b1;
			run_phase(ph == 4 ? 0 : ph);
		end

		// Column walk: a row with no end mark wraps after the last column
		write_config(20'd8192, 20'd5120, 20'd8192, 20'd3840, 20'd500, 20'd5000,
			20'd100, 20'd2000);
		for (int i = 0; i < COLS + 4; i++)
			add_pixel(rand_depth(), i % 16 == 0 || (i >= COLS - 2 && i <= COLS + 1),
				1'b0, i == 0);
		run_phase(0);

		// Row walk: one pixel per row until the row counter wraps
		write_config(20'd16000, 20'd0, 20'd2000, 20'hFFFF, 20'd0, 20'hFFFF,
			20'd0, 20'hFFFF);
		for (int i = 0; i < ROWS + 4; i++)
			add_pixel(rand_depth(), i % 16 == 0 || (i >= ROWS - 2 && i <= ROWS + 1),
				1'b1, i == 0);
		run_phase(0);

		// Drain, then allow for any stray result
		repeat (DRAIN) @(posedge clk);
		if (expected_results.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> depth_pixel_range_height_filter_top.f
rtl/dprhf_pkg.sv
rtl/dprhf_if.sv
rtl/dprhf_ctrl.sv
rtl/dprhf_datapath.sv
rtl/depth_pixel_range_height_filter_top.sv
tb/depth_pixel_range_height_filter_top_tb.sv
